// ===== rtl/core/lottery_pkg.sv =====
package lottery_pkg;

    localparam int MaxProcs  = 16;
    localparam int IdxBits   = $clog2(MaxProcs);
    localparam int CntBits   = $clog2(MaxProcs + 1);
    localparam int BurstBits = 8;
    localparam int PrioBits  = 5;
    localparam int TimeBits  = 12;
    localparam int TickBits  = 13;
    localparam logic [TimeBits-1:0] TimeMax   = '1;
    localparam logic [TickBits-1:0] TicketMax = '1;

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_SEAL  = 2'd2,
        KIND_DRAW  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_RUN     = 3'd1,
        ST_FULL       = 3'd2,
        ST_NOT_SEALED = 3'd3,
        ST_ALL_DONE   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SORT_SCAN,
        S_SORT_SWAP,
        S_TICKETS,
        S_DRAW,
        S_OUT
    } state_t;

endpackage

// ===== rtl/core/lottery_if.sv =====
interface lottery_in_if;
    import lottery_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [BurstBits-1:0] burst_in;
    logic [PrioBits-1:0]  prio_in;
    logic [TickBits-1:0]  drawn_ticket;
    modport source (output valid, kind, burst_in, prio_in, drawn_ticket, input ready);
    modport sink   (input valid, kind, burst_in, prio_in, drawn_ticket, output ready);
endinterface

interface lottery_out_if;
    import lottery_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [2:0]           status;
    logic [IdxBits-1:0]   proc_index;
    logic [BurstBits-1:0] remaining;
    logic [TimeBits-1:0]  elapsed;
    logic [TickBits-1:0]  ticket_total;
    logic                 all_finished;
    modport source (output valid, status, proc_index, remaining, elapsed, ticket_total,
                    all_finished, input ready);
    modport sink   (input valid, status, proc_index, remaining, elapsed, ticket_total,
                    all_finished, output ready);
endinterface

// ===== rtl/core/lottery_scheduler.sv =====
// Lottery scheduler with a one-unit quantum.
// Input channel "in": kind (clear, load, seal, draw) with burst_in, prio_in
// and drawn_ticket. Output channel "out": one transaction per input
// transaction with status, proc_index, remaining, elapsed, ticket_total and
// all_finished.
// Clear and load go from idle straight to the output state. Seal runs a
// selection sort one compare per cycle, then one ticket accumulation per
// entry. Draw walks the ticket ranges one entry per cycle.
// One transaction is in work at a time; in.ready is high only when idle.
// Results sit in an output register; a stalled receiver holds the block
// in its output state with the result stable until taken.
// Reset empties the table and zeroes counters and the sealed flag; table
// entries themselves are not cleared.
module lottery_scheduler
    import lottery_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lottery_in_if.sink    in,
    lottery_out_if.source out
);

    logic [BurstBits-1:0] burst_mem [MaxProcs];
    logic [PrioBits-1:0]  prio_mem  [MaxProcs];
    logic [IdxBits-1:0]   orig_mem  [MaxProcs];
    logic [TickBits-1:0]  tend_mem  [MaxProcs];

    state_t state_reg, state_next;
    logic [CntBits-1:0]  count_reg;
    logic [TimeBits-1:0] elapsed_reg, bsum_reg;
    logic [TickBits-1:0] tickets_reg;
    logic                sealed_reg;
    logic [CntBits-1:0]  i_reg, j_reg;
    logic [IdxBits-1:0]  pos_reg;
    logic [TickBits-1:0] run_reg, ticket_reg;
    logic [2:0]          status_reg;
    logic [IdxBits-1:0]  index_reg;
    logic [BurstBits-1:0] rem_reg;

    logic [IdxBits-1:0] i_idx, j_idx;
    logic [TickBits+1:0] gain, share, run_sum;
    logic [TimeBits:0]   bsum_sum;

    assign i_idx = i_reg[IdxBits-1:0];
    assign j_idx = j_reg[IdxBits-1:0];
    assign gain = (TickBits+2)'(burst_mem[i_idx]) + (TickBits+2)'(count_reg);
    assign share = (gain > (TickBits+2)'(prio_mem[i_idx]))
                   ? gain - (TickBits+2)'(prio_mem[i_idx]) : '0;
    assign run_sum = (TickBits+2)'(run_reg) + share;
    assign bsum_sum = (TimeBits+1)'(bsum_reg) + (TimeBits+1)'(in.burst_in);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in.valid)
                begin
                    unique case (kind_t'(in.kind))
                        KIND_SEAL: state_next = (count_reg == '0) ? S_TICKETS : S_SORT_SCAN;
                        KIND_DRAW: state_next = S_DRAW;
                        default:   state_next = S_OUT;
                    endcase
                end
            S_SORT_SCAN:
                if (j_reg >= count_reg) state_next = S_SORT_SWAP;
            S_SORT_SWAP:
                if (i_reg + 1'b1 >= count_reg) state_next = S_TICKETS;
                else                           state_next = S_SORT_SCAN;
            S_TICKETS:
                if (i_reg >= count_reg) state_next = S_OUT;
            S_DRAW:
                if (!sealed_reg || elapsed_reg == bsum_reg || ticket_reg == '0
                    || ticket_reg > tickets_reg || i_reg >= count_reg
                    || ticket_reg <= tend_mem[i_idx])
                    state_next = S_OUT;
            S_OUT:
                if (out.ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in.ready  = (state_reg == S_IDLE);
        out.valid = (state_reg == S_OUT);
        out.status       = status_reg;
        out.proc_index   = index_reg;
        out.remaining    = rem_reg;
        out.elapsed      = elapsed_reg;
        out.ticket_total = tickets_reg;
        out.all_finished = (elapsed_reg == bsum_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            elapsed_reg <= '0;
            bsum_reg    <= '0;
            tickets_reg <= '0;
            sealed_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && in.valid)
            begin
                unique case (kind_t'(in.kind))
                    KIND_CLEAR:
                    begin
                        count_reg   <= '0;
                        elapsed_reg <= '0;
                        bsum_reg    <= '0;
                        tickets_reg <= '0;
                        sealed_reg  <= 1'b0;
                    end
                    KIND_LOAD:
                        if (count_reg < CntBits'(MaxProcs))
                        begin
                            count_reg  <= count_reg + 1'b1;
                            bsum_reg   <= bsum_sum[TimeBits] ? TimeMax : bsum_sum[TimeBits-1:0];
                            sealed_reg <= 1'b0;
                        end
                    default: ;
                endcase
            end
            if (state_reg == S_TICKETS && i_reg >= count_reg)
            begin
                tickets_reg <= run_reg;
                sealed_reg  <= 1'b1;
            end
            if (state_reg == S_DRAW && state_next == S_OUT && sealed_reg
                && elapsed_reg != bsum_reg && ticket_reg != '0
                && ticket_reg <= tickets_reg && i_reg < count_reg
                && burst_mem[i_idx] != '0 && elapsed_reg != TimeMax)
                elapsed_reg <= elapsed_reg + 1'b1;
        end
    end

    // datapath: table, sequencer counters and result register
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                i_reg      <= '0;
                j_reg      <= CntBits'(1);
                pos_reg    <= '0;
                run_reg    <= '0;
                ticket_reg <= in.drawn_ticket;
                status_reg <= (in.valid && kind_t'(in.kind) == KIND_LOAD
                               && count_reg >= CntBits'(MaxProcs)) ? ST_FULL : ST_OK;
                index_reg  <= '0;
                rem_reg    <= '0;
                if (in.valid && kind_t'(in.kind) == KIND_LOAD
                    && count_reg < CntBits'(MaxProcs))
                begin
                    burst_mem[count_reg[IdxBits-1:0]] <= in.burst_in;
                    prio_mem[count_reg[IdxBits-1:0]]  <= in.prio_in;
                    orig_mem[count_reg[IdxBits-1:0]]  <= count_reg[IdxBits-1:0];
                    tend_mem[count_reg[IdxBits-1:0]]  <= '0;
                end
            end
            S_SORT_SCAN:
                if (j_reg < count_reg)
                begin
                    if (prio_mem[j_idx] < prio_mem[pos_reg]) pos_reg <= j_idx;
                    j_reg <= j_reg + 1'b1;
                end
            S_SORT_SWAP:
            begin
                if (pos_reg != i_idx)
                begin
                    burst_mem[i_idx]   <= burst_mem[pos_reg];
                    burst_mem[pos_reg] <= burst_mem[i_idx];
                    prio_mem[i_idx]    <= prio_mem[pos_reg];
                    prio_mem[pos_reg]  <= prio_mem[i_idx];
                    orig_mem[i_idx]    <= orig_mem[pos_reg];
                    orig_mem[pos_reg]  <= orig_mem[i_idx];
                end
                if (i_reg + 1'b1 >= count_reg)
                    i_reg <= '0;
                else
                begin
                    i_reg   <= i_reg + 1'b1;
                    pos_reg <= i_idx + 1'b1;
                    j_reg   <= i_reg + 2'd2;
                end
            end
            S_TICKETS:
                if (i_reg < count_reg)
                begin
                    run_reg <= (run_sum > (TickBits+2)'(TicketMax))
                               ? TicketMax : run_sum[TickBits-1:0];
                    tend_mem[i_idx] <= (run_sum > (TickBits+2)'(TicketMax))
                                       ? TicketMax : run_sum[TickBits-1:0];
                    i_reg <= i_reg + 1'b1;
                end
            S_DRAW:
                priority if (!sealed_reg)
                    status_reg <= ST_NOT_SEALED;
                else if (elapsed_reg == bsum_reg)
                    status_reg <= ST_ALL_DONE;
                else if (ticket_reg == '0 || ticket_reg > tickets_reg || i_reg >= count_reg)
                    status_reg <= ST_NO_RUN;
                else if (ticket_reg <= tend_mem[i_idx])
                begin
                    if (burst_mem[i_idx] == '0)
                        status_reg <= ST_NO_RUN;
                    else
                    begin
                        burst_mem[i_idx] <= burst_mem[i_idx] - 1'b1;
                        index_reg <= orig_mem[i_idx];
                        rem_reg   <= burst_mem[i_idx] - 1'b1;
                    end
                end
                else
                    i_reg <= i_reg + 1'b1;
            S_OUT: ;
            default: ;
        endcase
    end

endmodule

// ===== rtl/core/lottery_checker.sv =====
module lottery_assertions
    import lottery_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [2:0]          status,
    input logic [TimeBits-1:0] elapsed
);

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("stalled result changed");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_ALL_DONE)
        else $error("status code out of range");

    a_elapsed_step: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !in_ready |=> elapsed == $past(elapsed)
            || elapsed == $past(elapsed) + 1'b1 || elapsed == '0)
        else $error("elapsed jumped");

    a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("not idle after result taken");

endmodule

bind lottery_scheduler lottery_assertions u_lottery_assertions (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in.ready),
    .out_valid (out.valid),
    .out_ready (out.ready),
    .status    (out.status),
    .elapsed   (out.elapsed)
);
